// ----- src/assert_macros.svh -----
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/slcp_pkg.sv -----
`default_nettype none

package slcp_pkg;

  localparam int MAX_BYTES = 8;
  localparam int NIBBLES   = 2 * MAX_BYTES;

  localparam int CHAR_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int IDENT_W   = 32;
  localparam int LENGTH_W  = 4;
  localparam int PAYLOAD_W = 64;

  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LO_T   = 8'h74;
  localparam logic [CHAR_W-1:0] CH_UP_T   = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LO_R   = 8'h72;
  localparam logic [CHAR_W-1:0] CH_UP_R   = 8'h52;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
  localparam logic [CHAR_W-1:0] CASE_FOLD = 8'hDF;

  // Digit value 0..15, HEX_BAD for a character that is not hex.
  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_TYPE = 3'd1,
    ST_BAD_ID   = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_BAD_DATA = 3'd4,
    ST_BAD_TERM = 3'd5
  } status_t;

  typedef struct packed {
    status_t                status;
    logic                   extended;
    logic                   remote;
    logic [IDENT_W-1:0]     ident;
    logic [LENGTH_W-1:0]    length;
    logic [PAYLOAD_W-1:0]   payload;
  } frame_t;

  function automatic logic [4:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] u;
    logic [CHAR_W-1:0] d;
    u = c & CASE_FOLD;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return d[4:0];
    end
    if (u >= CH_UP_A && u <= CH_UP_F) begin
      d = u - CH_UP_A + 8'd10;
      return d[4:0];
    end
    return HEX_BAD;
  endfunction

endpackage

`default_nettype wire

// ----- src/slcp_char_if.sv -----
`default_nettype none

interface slcp_char_if;
  logic                          valid;
  logic                          ready;
  logic [slcp_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ----- src/slcp_frame_if.sv -----
`default_nettype none

interface slcp_frame_if;
  logic                             valid;
  logic                             ready;
  logic [slcp_pkg::STATUS_W-1:0]    status;
  logic                             extended;
  logic                             remote;
  logic [slcp_pkg::IDENT_W-1:0]     ident;
  logic [slcp_pkg::LENGTH_W-1:0]    length;
  logic [slcp_pkg::PAYLOAD_W-1:0]   payload;

  modport source (output valid, output status, output extended, output remote,
                  output ident, output length, output payload, input ready);
  modport sink   (input valid, input status, input extended, input remote,
                  input ident, input length, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/slcan_ascii_frame_parser_unit.sv -----
// A frame appears on out_ch the cycle after its carriage return is accepted,
// later when it lands in the skid entry behind a frame that out_ch has not taken.
// Throughput: one character per cycle while in_ch is ready; the line state registers update in a single pass.
// A two-entry output buffer (result register plus skid) keeps in_ch ready while a
// result waits; in_ch stalls only when both entries are full.
// Reset: synchronous, active low; clears the line state and empties both output entries.
`default_nettype none

`include "assert_macros.svh"

module slcan_ascii_frame_parser_unit (
  input  wire               clk,
  input  wire               rst_n,
  slcp_char_if.sink         in_ch,
  slcp_frame_if.source      out_ch
);

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_TERM,
    PH_DRAIN
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic [slcp_pkg::IDENT_W-1:0]        id_accum_r, id_accum_nxt;
  logic [3:0]                          digit_count_r, digit_count_nxt;
  logic [slcp_pkg::LENGTH_W-1:0]       len_r, len_nxt;
  logic [slcp_pkg::PAYLOAD_W-1:0]      data_r, data_nxt;
  logic [4:0]                          nibble_count_r, nibble_count_nxt;
  logic                                flag_ext_r, flag_ext_nxt;
  logic                                flag_rtr_r, flag_rtr_nxt;
  slcp_pkg::status_t                   err_r, err_nxt;

  slcp_pkg::frame_t                    out_r, out_nxt;
  slcp_pkg::frame_t                    skid_r, skid_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                skid_valid_r, skid_valid_nxt;

  slcp_pkg::frame_t                    result;
  logic                                in_acc;
  logic                                push;
  logic                                out_take;
  logic                                is_cr;
  logic [4:0]                          hv;
  logic [4:0]                          nib_inc;
  logic [slcp_pkg::CHAR_W-1:0]         len_char;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_cr       = (in_ch.char_in == slcp_pkg::CH_CR);
  assign push        = in_acc && is_cr;
  assign out_take    = out_valid_r && out_ch.ready;
  assign hv          = slcp_pkg::hex_value(in_ch.char_in);
  assign nib_inc     = nibble_count_r + 5'd1;
  assign len_char    = in_ch.char_in - slcp_pkg::CH_ZERO;

  // Result for a carriage return in the current phase.
  always_comb begin
    result = '0;
    if (err_r != slcp_pkg::ST_OK) begin
      result.status = err_r;
    end else begin
      case (phase_r)
        PH_TYPE: result.status = slcp_pkg::ST_BAD_TYPE;
        PH_ID:   result.status = slcp_pkg::ST_BAD_ID;
        PH_LEN:  result.status = slcp_pkg::ST_BAD_LEN;
        PH_DATA: result.status = slcp_pkg::ST_BAD_DATA;
        default: begin
          result.status   = slcp_pkg::ST_OK;
          result.extended = flag_ext_r;
          result.remote   = flag_rtr_r;
          result.ident    = id_accum_r;
          result.length   = len_r;
          result.payload  = data_r;
        end
      endcase
    end
  end

  // Line state update.
  always_comb begin
    phase_nxt        = phase_r;
    id_accum_nxt     = id_accum_r;
    digit_count_nxt  = digit_count_r;
    len_nxt          = len_r;
    data_nxt         = data_r;
    nibble_count_nxt = nibble_count_r;
    flag_ext_nxt     = flag_ext_r;
    flag_rtr_nxt     = flag_rtr_r;
    err_nxt          = err_r;
    if (in_acc) begin
      if (is_cr) begin
        // End of line: return to the idle line state.
        phase_nxt        = PH_TYPE;
        id_accum_nxt     = '0;
        digit_count_nxt  = '0;
        len_nxt          = '0;
        data_nxt         = '0;
        nibble_count_nxt = '0;
        flag_ext_nxt     = 1'b0;
        flag_rtr_nxt     = 1'b0;
        err_nxt          = slcp_pkg::ST_OK;
      end else begin
        case (phase_r)
          PH_TYPE: begin
            if (in_ch.char_in inside {slcp_pkg::CH_LO_T, slcp_pkg::CH_UP_T,
                                      slcp_pkg::CH_LO_R, slcp_pkg::CH_UP_R}) begin
              flag_ext_nxt = (in_ch.char_in == slcp_pkg::CH_UP_T) ||
                             (in_ch.char_in == slcp_pkg::CH_UP_R);
              flag_rtr_nxt = (in_ch.char_in == slcp_pkg::CH_LO_R) ||
                             (in_ch.char_in == slcp_pkg::CH_UP_R);
              phase_nxt    = PH_ID;
            end else begin
              err_nxt   = slcp_pkg::ST_BAD_TYPE;
              phase_nxt = PH_DRAIN;
            end
          end
          PH_ID: begin
            if (hv == slcp_pkg::HEX_BAD) begin
              err_nxt   = slcp_pkg::ST_BAD_ID;
              phase_nxt = PH_DRAIN;
            end else begin
              id_accum_nxt    = {id_accum_r[slcp_pkg::IDENT_W-5:0], hv[3:0]};
              digit_count_nxt = digit_count_r + 4'd1;
              if (digit_count_nxt >= (flag_ext_r ? 4'd8 : 4'd3)) begin
                phase_nxt = PH_LEN;
              end
            end
          end
          PH_LEN: begin
            if (in_ch.char_in >= slcp_pkg::CH_ZERO &&
                len_char <= slcp_pkg::CHAR_W'(slcp_pkg::MAX_BYTES)) begin
              len_nxt   = len_char[slcp_pkg::LENGTH_W-1:0];
              phase_nxt = (flag_rtr_r || len_nxt == '0) ? PH_TERM : PH_DATA;
            end else begin
              err_nxt   = slcp_pkg::ST_BAD_LEN;
              phase_nxt = PH_DRAIN;
            end
          end
          PH_DATA: begin
            if (hv == slcp_pkg::HEX_BAD ||
                nibble_count_r >= 5'(slcp_pkg::NIBBLES)) begin
              err_nxt   = slcp_pkg::ST_BAD_DATA;
              phase_nxt = PH_DRAIN;
            end else begin
              // High nibble of each byte first.
              for (int i = 0; i < slcp_pkg::NIBBLES; i++) begin
                if (nibble_count_r == 5'(i)) begin
                  data_nxt[(i >> 1) * 8 + (((i & 1) == 1) ? 0 : 4) +: 4] = hv[3:0];
                end
              end
              nibble_count_nxt = nib_inc;
              if (nib_inc >= {len_r, 1'b0}) begin
                phase_nxt = PH_TERM;
              end
            end
          end
          PH_TERM: begin
            err_nxt   = slcp_pkg::ST_BAD_TERM;
            phase_nxt = PH_DRAIN;
          end
          default: begin
            // Drain: drop characters until the carriage return.
          end
        endcase
      end
    end
  end

  // Result register and skid entry.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TYPE;
      id_accum_r     <= '0;
      digit_count_r  <= '0;
      len_r          <= '0;
      data_r         <= '0;
      nibble_count_r <= '0;
      flag_ext_r     <= 1'b0;
      flag_rtr_r     <= 1'b0;
      err_r          <= slcp_pkg::ST_OK;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      id_accum_r     <= id_accum_nxt;
      digit_count_r  <= digit_count_nxt;
      len_r          <= len_nxt;
      data_r         <= data_nxt;
      nibble_count_r <= nibble_count_nxt;
      flag_ext_r     <= flag_ext_nxt;
      flag_rtr_r     <= flag_rtr_nxt;
      err_r          <= err_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.extended = out_r.extended;
  assign out_ch.remote   = out_r.remote;
  assign out_ch.ident    = out_r.ident;
  assign out_ch.length   = out_r.length;
  assign out_ch.payload  = out_r.payload;

  `ASSERT_CLK(a_skid_behind_out, !skid_valid_r || out_valid_r,
              "skid entry valid while result register empty")
  `ASSERT_NEXT(a_cr_gives_result, push, out_valid_r,
               "carriage return did not produce a result")
  `ASSERT_CLK(a_drain_has_error, phase_r != PH_DRAIN || err_r != slcp_pkg::ST_OK,
              "drain phase without a recorded error")
  `ASSERT_CLK(a_error_fields_zero,
              !out_valid_r || out_r.status == slcp_pkg::ST_OK ||
              (out_r.ident == '0 && out_r.payload == '0 && out_r.length == '0),
              "error result carries nonzero frame fields")

endmodule

`default_nettype wire

// ----- dv/slcp_line_checker.sv -----
`default_nettype none

module slcp_line_checker (
  input  wire   clk,
  input  wire   rst_n,
  slcp_char_if  chars,
  slcp_frame_if frames,
  output int    fail_count,
  output int    frames_owed
);

  typedef enum logic [2:0] {
    LP_TYPE,
    LP_ID,
    LP_LEN,
    LP_DATA,
    LP_TERM,
    LP_DRAIN
  } line_phase_t;

  line_phase_t                    ph;
  logic [slcp_pkg::IDENT_W-1:0]   id_acc;
  logic [3:0]                     id_digits;
  logic [slcp_pkg::LENGTH_W-1:0]  dlc;
  logic [slcp_pkg::PAYLOAD_W-1:0] data_acc;
  logic [4:0]                     nib;
  logic                           ext_f;
  logic                           rtr_f;
  slcp_pkg::status_t              err;

  slcp_pkg::frame_t frames_due[$];
  int     errs = 0;

  function automatic logic [4:0] nibble_of(input logic [slcp_pkg::CHAR_W-1:0] c);
    logic [slcp_pkg::CHAR_W-1:0] d;
    if (c >= slcp_pkg::CH_ZERO && c <= slcp_pkg::CH_NINE) begin
      d = c - slcp_pkg::CH_ZERO;
    end else if (c >= slcp_pkg::CH_UP_A && c <= slcp_pkg::CH_UP_F) begin
      d = c - slcp_pkg::CH_UP_A + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h61 + 8'd10;
    end else begin
      return slcp_pkg::HEX_BAD;
    end
    return d[4:0];
  endfunction

  function automatic int field_diff(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_line();
    ph        = LP_TYPE;
    id_acc    = '0;
    id_digits = '0;
    dlc       = '0;
    data_acc  = '0;
    nib       = '0;
    ext_f     = 1'b0;
    rtr_f     = 1'b0;
    err       = slcp_pkg::ST_OK;
  endtask

  task automatic abort_line(input slcp_pkg::status_t code);
    err = code;
    ph  = LP_DRAIN;
  endtask

  task automatic parse_char(input logic [slcp_pkg::CHAR_W-1:0] c);
    slcp_pkg::frame_t            f;
    slcp_pkg::status_t           st;
    logic [4:0]                  v;
    logic [slcp_pkg::CHAR_W-1:0] d;
    int                          sh;
    if (c == slcp_pkg::CH_CR) begin
      st = err;
      if (st == slcp_pkg::ST_OK) begin
        case (ph)
          LP_TYPE: st = slcp_pkg::ST_BAD_TYPE;
          LP_ID:   st = slcp_pkg::ST_BAD_ID;
          LP_LEN:  st = slcp_pkg::ST_BAD_LEN;
          LP_DATA: st = slcp_pkg::ST_BAD_DATA;
          default: ;
        endcase
      end
      f = '0;
      f.status = st;
      if (st == slcp_pkg::ST_OK) begin
        f.extended = ext_f;
        f.remote   = rtr_f;
        f.ident    = id_acc;
        f.length   = dlc;
        f.payload  = data_acc;
      end
      frames_due.push_back(f);
      clear_line();
    end else begin
      case (ph)
        LP_TYPE: begin
          if (c == slcp_pkg::CH_LO_T || c == slcp_pkg::CH_UP_T ||
              c == slcp_pkg::CH_LO_R || c == slcp_pkg::CH_UP_R) begin
            ext_f = (c == slcp_pkg::CH_UP_T || c == slcp_pkg::CH_UP_R);
            rtr_f = (c == slcp_pkg::CH_LO_R || c == slcp_pkg::CH_UP_R);
            ph    = LP_ID;
          end else begin
            abort_line(slcp_pkg::ST_BAD_TYPE);
          end
        end
        LP_ID: begin
          v = nibble_of(c);
          if (v == slcp_pkg::HEX_BAD) begin
            abort_line(slcp_pkg::ST_BAD_ID);
          end else begin
            id_acc    = {id_acc[slcp_pkg::IDENT_W-5:0], v[3:0]};
            id_digits = id_digits + 4'd1;
            if (id_digits >= (ext_f ? 4'd8 : 4'd3)) ph = LP_LEN;
          end
        end
        LP_LEN: begin
          if (c >= slcp_pkg::CH_ZERO && c <= slcp_pkg::CH_ZERO + slcp_pkg::MAX_BYTES) begin
            d   = c - slcp_pkg::CH_ZERO;
            dlc = d[slcp_pkg::LENGTH_W-1:0];
            ph  = (rtr_f || dlc == 0) ? LP_TERM : LP_DATA;
          end else begin
            abort_line(slcp_pkg::ST_BAD_LEN);
          end
        end
        LP_DATA: begin
          v = nibble_of(c);
          if (v == slcp_pkg::HEX_BAD || nib >= slcp_pkg::NIBBLES) begin
            abort_line(slcp_pkg::ST_BAD_DATA);
          end else begin
            // high nibble of each byte arrives first
            sh       = int'(nib[4:1]) * 8 + (nib[0] ? 0 : 4);
            data_acc = data_acc | ({60'd0, v[3:0]} << sh);
            nib      = nib + 5'd1;
            if (int'(nib) >= 2 * int'(dlc)) ph = LP_TERM;
          end
        end
        LP_TERM: abort_line(slcp_pkg::ST_BAD_TERM);
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    slcp_pkg::frame_t want;
    if (!rst_n) begin
      clear_line();
      frames_due.delete();
    end else begin
      if (chars.valid && chars.ready) parse_char(chars.char_in);
      if (frames.valid && frames.ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame: expected none, actual status %0d ident %0h",
                   $time, frames.status, frames.ident);
          errs++;
        end else begin
          want = frames_due.pop_front();
          errs += field_diff("status", 64'(want.status), 64'(frames.status));
          errs += field_diff("extended", 64'(want.extended), 64'(frames.extended));
          errs += field_diff("remote", 64'(want.remote), 64'(frames.remote));
          errs += field_diff("ident", 64'(want.ident), 64'(frames.ident));
          errs += field_diff("length", 64'(want.length), 64'(frames.length));
          errs += field_diff("payload", want.payload, frames.payload);
        end
      end
    end
    // publish after the edge so readers never race the update
    fail_count  <= errs;
    frames_owed <= frames_due.size();
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_CHARS     = 1000;
  localparam int SETTLE_CYCLES  = 10;

  localparam logic [slcp_pkg::CHAR_W-1:0] BORDER_CHARS [10] = '{
    8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF, 8'h39, 8'h38
  };

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  slcp_char_if  in_ch();
  slcp_frame_if out_ch();

  slcan_ascii_frame_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int fail_count;
  int frames_owed;

  slcp_line_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars       (in_ch),
    .frames      (out_ch),
    .fail_count  (fail_count),
    .frames_owed (frames_owed)
  );

  logic [slcp_pkg::CHAR_W-1:0] line_q[$];
  int chars_sent  = 0;
  int idle_cycles = 0;
  bit steady_line = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [slcp_pkg::CHAR_W-1:0] hex_char(input logic [3:0] n);
    if (n < 10) return slcp_pkg::CH_ZERO + n;
    if ($urandom_range(0, 1) == 1) return slcp_pkg::CH_UP_A + n - 4'd10;
    return 8'h61 + n - 4'd10;
  endfunction

  function automatic logic [slcp_pkg::CHAR_W-1:0] odd_char();
    if ($urandom_range(0, 1) == 1) return BORDER_CHARS[$urandom_range(0, 9)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Drop the receiver's ready in bursts, now and then for a long stretch.
  initial begin : ready_gen
    int hold;
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      hold = gap_len();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL slcan_ascii_frame_parser_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_char(input logic [slcp_pkg::CHAR_W-1:0] c);
    int gap;
    gap = steady_line ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk); while (!in_ch.ready);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_hex(input logic [63:0] val, input int n);
    for (int i = n - 1; i >= 0; i--) line_q.push_back(hex_char(val[4*i +: 4]));
  endtask

  task automatic add_frame(input bit ext, input bit rtr, input int len,
                           input logic [31:0] id, input logic [63:0] data);
    line_q.push_back(ext ? (rtr ? slcp_pkg::CH_UP_R : slcp_pkg::CH_UP_T)
                         : (rtr ? slcp_pkg::CH_LO_R : slcp_pkg::CH_LO_T));
    push_hex({32'd0, id}, ext ? 8 : 3);
    line_q.push_back(slcp_pkg::CH_ZERO + 8'(len));
    if (!rtr) begin
      for (int b = 0; b < len; b++) push_hex({56'd0, data[8*b +: 8]}, 2);
    end
  endtask

  task automatic directed_line(input string s);
    push_text(s);
    line_q.push_back(slcp_pkg::CH_CR);
    send_line();
  endtask

  task automatic random_line();
    int kind;
    int cut;
    int pos;
    logic [slcp_pkg::CHAR_W-1:0] b;
    add_frame(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
              $urandom_range(0, slcp_pkg::MAX_BYTES), $urandom, {$urandom, $urandom});
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
    end else if (kind < 75) begin
      // truncate anywhere, down to an empty line
      cut = $urandom_range(0, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end else if (kind < 85) begin
      pos = $urandom_range(0, line_q.size() - 1);
      line_q[pos] = odd_char();
    end else if (kind < 93) begin
      repeat ($urandom_range(1, 3)) begin
        do b = 8'($urandom_range(0, 255)); while (b == slcp_pkg::CH_CR);
        line_q.push_back(b);
      end
    end else begin
      line_q.delete();
      repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(0, 255)));
    end
    line_q.push_back(slcp_pkg::CH_CR);
    steady_line = ($urandom_range(0, 9) < 3);
    send_line();
  endtask

  initial begin : stimulus
    int base;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    directed_line("");
    line_q.push_back(8'hFF);
    directed_line("");
    directed_line("t1F");
    directed_line("T1234567g");
    directed_line("t7FF");
    directed_line("t7FF9");
    directed_line("t000/");
    directed_line("t1232AB");
    directed_line("t1232ABZZ");
    directed_line("t0000");
    directed_line("TFFFFFFFF8FfFFffFFFFfFFfFFff");
    directed_line("T0000000080123456789abcdef");
    directed_line("r7FF8");
    directed_line("R1FFFFFFF0");
    directed_line("t12310");
    steady_line = 1'b0;
    directed_line("t5a13aBc");

    base = chars_sent;
    while (chars_sent - base < RAND_CHARS) random_line();
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (frames_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && frames_owed == 0) begin
      $display("PASS slcan_ascii_frame_parser_unit");
    end else begin
      $display("FAIL slcan_ascii_frame_parser_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- slcan_ascii_frame_parser_unit.f -----
+incdir+src
src/slcp_pkg.sv
src/slcp_char_if.sv
src/slcp_frame_if.sv
src/slcan_ascii_frame_parser_unit.sv
dv/slcp_line_checker.sv
dv/tb.sv
